// ===== sv/oaht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared constants and codes for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int MAX_SLOTS = 128;
	localparam int KEY_BITS  = 31;

	// slot address and probe count widths follow the store depth
	localparam int SLOT_AW = $clog2(MAX_SLOTS);
	localparam int CNT_W   = SLOT_AW + 1;

	// fixed port widths
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 7;
	localparam int COLL_W   = 8;
	localparam int CFG_W    = 8;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 8'd101;

	// register index, taken from paddr[2]
	localparam logic REG_TABLE_SIZE = 1'b0;
	localparam logic REG_PROBE_MODE = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_SEARCH = 2'd2
	} command_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_CLEARED   = 3'd4,
		ST_ZERO_KEY  = 3'd5
	} status_t;

endpackage
`default_nettype wire

// ===== sv/oaht_mod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_mod
// Iterative key modulo unit: restoring division, one key bit per cycle.
// ----------------------------------------------------------------------------
module oaht_mod (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [oaht_pkg::KEY_BITS-1:0]  dividend,
	input  wire logic [oaht_pkg::CNT_W-1:0]     divisor,
	output logic                                done,
	output logic [oaht_pkg::SLOT_AW-1:0]        rem
);
	import oaht_pkg::*;

	localparam int BC_W = $clog2(KEY_BITS + 1);

	logic                run_q;
	logic                done_q;
	logic [BC_W-1:0]     cnt_q;
	logic [KEY_BITS-1:0] dvd_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W:0]      trial;
	logic [CNT_W:0]      diff;

	assign trial = {rem_q, dvd_q[KEY_BITS-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= BC_W'(KEY_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BC_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			// remainder stays below divisor, so it fits back in CNT_W bits
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[CNT_W-1:0];
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q[SLOT_AW-1:0];

endmodule
`default_nettype wire

// ===== sv/oaht_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_ram
// Single-port key store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module oaht_ram (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic                           re,
	input  wire logic [oaht_pkg::SLOT_AW-1:0]   addr,
	input  wire logic [oaht_pkg::KEY_BITS-1:0]  wdata,
	output logic [oaht_pkg::KEY_BITS-1:0]       rdata
);
	import oaht_pkg::*;

	logic [KEY_BITS-1:0] mem_q [MAX_SLOTS];
	logic [KEY_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/open_addressing_hash_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Hash table of nonzero keys with linear or quadratic probing over m slots.
// ----------------------------------------------------------------------------
// timing: clear and zero key give their result in the cycle after start;
//   insert and search first run the key modulo (one key bit a cycle), then
//   read the store and compare for each probe, up to m probes.
// one item at a time: busy stays high until the result strobe; the receiver
//   cannot stall, done is high for exactly one cycle per result.
// reset: table empty through per-slot valid bits, table_size 101, linear mode.
module open_addressing_hash_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [oaht_pkg::CMD_W-1:0]     command,
	input  wire logic [oaht_pkg::KEY_BITS-1:0]  key,
	output logic                                done,
	output oaht_pkg::status_t                   status,
	output logic [oaht_pkg::SLOT_W-1:0]         slot_index,
	output logic [oaht_pkg::COLL_W-1:0]         collisions,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [oaht_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [oaht_pkg::PDATA_W-1:0]   pwdata,
	output logic [oaht_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);
	import oaht_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_READ,
		S_CHECK
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     table_size_q;
	logic                 probe_mode_q;
	logic [MAX_SLOTS-1:0] valid_q;
	logic                 vld_rd_q;
	logic                 search_q;
	logic                 quad_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [CNT_W-1:0]     m_q;
	logic [SLOT_AW-1:0]   slot_q;
	logic [SLOT_AW-1:0]   step_q;
	logic [CNT_W-1:0]     probe_q;
	logic                 done_q;
	status_t              status_q;
	logic [SLOT_W-1:0]    slot_idx_q;
	logic [COLL_W-1:0]    coll_q;

	logic                 accept;
	logic                 cfg_wr;
	logic                 div_go;
	logic                 div_done;
	logic [SLOT_AW-1:0]   div_rem;
	logic [CNT_W-1:0]     m_act;
	logic [CNT_W-1:0]     slot_sum;
	logic [SLOT_AW-1:0]   slot_nxt;
	logic [CNT_W-1:0]     step_a;
	logic [CNT_W-1:0]     step_b;
	logic [SLOT_AW-1:0]   step_nxt;
	logic [CNT_W-1:0]     probe_inc;
	logic                 entry_empty;
	logic                 entry_hit;
	logic                 ram_we;
	logic                 ram_re;
	logic [KEY_BITS-1:0]  ram_rdata;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign div_go = accept && (key != '0)
		&& ((command == CMD_INSERT) || (command == CMD_SEARCH));

	// out-of-range table sizes clamp to 1..MAX_SLOTS
	always_comb begin
		if (table_size_q == '0) begin
			m_act = CNT_W'(1);
		end else if (table_size_q > MAX_SLOTS) begin
			m_act = CNT_W'(MAX_SLOTS);
		end else begin
			m_act = CNT_W'(table_size_q);
		end
	end

	// next probe: slot += step (mod m); quadratic step grows by 2 (mod m)
	always_comb begin
		slot_sum = {1'b0, slot_q} + {1'b0, step_q};
		slot_nxt = (slot_sum >= m_q) ? SLOT_AW'(slot_sum - m_q) : slot_sum[SLOT_AW-1:0];
		step_a   = {1'b0, step_q} + CNT_W'(2);
		step_b   = (step_a >= m_q) ? (step_a - m_q) : step_a;
		// second fold only matters for a one-slot table
		step_nxt = (step_b >= m_q) ? SLOT_AW'(step_b - m_q) : step_b[SLOT_AW-1:0];
	end

	assign probe_inc   = probe_q + 1'b1;
	assign entry_empty = !vld_rd_q;
	assign entry_hit   = vld_rd_q && (ram_rdata == key_q);
	assign ram_re      = (state_q == S_READ);
	assign ram_we      = (state_q == S_CHECK) && !search_q && entry_empty;

	oaht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (key),
		.divisor  (m_act),
		.done     (div_done),
		.rem      (div_rem)
	);

	oaht_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (slot_q),
		.wdata (key_q),
		.rdata (ram_rdata)
	);

	// configuration port
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
			probe_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_TABLE_SIZE: table_size_q <= pwdata[CFG_W-1:0];
				REG_PROBE_MODE: probe_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TABLE_SIZE: prdata = {{(PDATA_W-CFG_W){1'b0}}, table_size_q};
			REG_PROBE_MODE: prdata = {{(PDATA_W-1){1'b0}}, probe_mode_q};
			default:        prdata = '0;
		endcase
	end

	// control and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			vld_rd_q   <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= ST_INSERTED;
			slot_idx_q <= '0;
			coll_q     <= '0;
			search_q   <= 1'b0;
			quad_q     <= 1'b0;
			m_q        <= CNT_W'(1);
			slot_q     <= '0;
			step_q     <= '0;
			probe_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						search_q <= (command == CMD_SEARCH);
						quad_q   <= probe_mode_q;
						m_q      <= m_act;
						unique case (command)
							CMD_CLEAR: begin
								valid_q    <= '0;
								done_q     <= 1'b1;
								status_q   <= ST_CLEARED;
								slot_idx_q <= '0;
								coll_q     <= '0;
							end
							CMD_INSERT, CMD_SEARCH: begin
								if (key == '0) begin
									done_q     <= 1'b1;
									status_q   <= ST_ZERO_KEY;
									slot_idx_q <= '0;
									coll_q     <= '0;
								end else begin
									state_q <= S_DIV;
								end
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						slot_q  <= div_rem;
						step_q  <= (m_q == CNT_W'(1)) ? '0 : SLOT_AW'(1);
						probe_q <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					vld_rd_q <= valid_q[slot_q];
					state_q  <= S_CHECK;
				end
				S_CHECK: begin
					priority if (!search_q && entry_empty) begin
						valid_q[slot_q] <= 1'b1;
						done_q          <= 1'b1;
						status_q        <= ST_INSERTED;
						slot_idx_q      <= SLOT_W'(slot_q);
						coll_q          <= COLL_W'(probe_q);
						state_q         <= S_IDLE;
					end else if (search_q && entry_hit) begin
						done_q     <= 1'b1;
						status_q   <= ST_FOUND;
						slot_idx_q <= SLOT_W'(slot_q);
						coll_q     <= COLL_W'(probe_q);
						state_q    <= S_IDLE;
					end else if (search_q && entry_empty) begin
						// the probe that met the empty slot counts too
						done_q     <= 1'b1;
						status_q   <= ST_NOT_FOUND;
						slot_idx_q <= '0;
						coll_q     <= COLL_W'(probe_inc);
						state_q    <= S_IDLE;
					end else if (probe_inc == m_q) begin
						done_q     <= 1'b1;
						status_q   <= search_q ? ST_NOT_FOUND : ST_FULL;
						slot_idx_q <= '0;
						coll_q     <= COLL_W'(m_q);
						state_q    <= S_IDLE;
					end else begin
						probe_q <= probe_inc;
						slot_q  <= slot_nxt;
						if (quad_q) begin
							step_q <= step_nxt;
						end
						state_q <= S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign slot_index = slot_idx_q;
	assign collisions = coll_q;

endmodule
`default_nettype wire
